FILE: hw/rtl/sptf_pkg.sv
// Shared types, sizes, opcodes and the output rounding function for the
// sparse-tap complex FIR. No dependencies; all other files but sptf_ram import it.
`timescale 1ns / 1ps

package sptf_pkg;

    localparam int MAX_TAPS      = 32;
    localparam int HISTORY_DEPTH = 256;

    localparam int HIST_AW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int TAP_IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int SIB_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int CFG_W     = 6;
    localparam int DELAY_W   = 8;
    localparam int CMP_W     = ((TAP_IDX_W > CFG_W) ? TAP_IDX_W : CFG_W) + 1;
    // wide enough for wp + HISTORY_DEPTH - delay
    localparam int SLOT_W    = ((HIST_AW > DELAY_W) ? HIST_AW : DELAY_W) + 2;
    localparam int ACC_W     = 34 + TAP_IDX_W;
    localparam int SAMPLE_W  = 32;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic signed [15:0] coeff_re;
        logic signed [15:0] coeff_im;
    } tap_t;

    // one tap's worth of work handed to the MAC in the cycle its read issues
    typedef struct packed {
        logic               use_tap;
        logic signed [15:0] coeff_re;
        logic signed [15:0] coeff_im;
    } mac_issue_t;

    typedef struct packed {
        logic [15:0] value;
        logic        clip;
    } rnd_t;

    // add half an LSB, floor shift by 15, clip to 16 bits
    function automatic rnd_t round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] t;
        logic signed [ACC_W:0] q;
        rnd_t                  r;
        t = {acc[ACC_W-1], acc} + (ACC_W+1)'(16384);
        q = t >>> 15;
        if (q > (ACC_W+1)'(32767)) begin
            r.value = 16'h7fff;
            r.clip  = 1'b1;
        end
        else if (q < -(ACC_W+1)'(32768)) begin
            r.value = 16'h8000;
            r.clip  = 1'b1;
        end
        else begin
            r.value = q[15:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/sptf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sptf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/sptf_tap_cell.sv
// One cell of the tap ring: holds a tap's delay and coefficient, loads it
// directly or takes its neighbor's tap when the ring rotates. Uses sptf_pkg.
`timescale 1ns / 1ps

module sptf_tap_cell
    import sptf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load_en,
    input  tap_t load_tap,
    input  logic shift_en,
    input  tap_t neighbor_tap,
    output tap_t tap
);

    tap_t tap_reg;
    tap_t tap_next;

    always_comb
    begin
        tap_next = tap_reg;
        if (shift_en)
        begin
            tap_next = neighbor_tap;
        end
        else if (load_en)
        begin
            tap_next = load_tap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else
        begin
            tap_reg <= tap_next;
        end
    end

    assign tap = tap_reg;

endmodule

FILE: hw/rtl/sptf_mac.sv
// Complex multiply-accumulate: aligns the coefficient with the history read,
// registers the four partial products, then accumulates. Uses sptf_pkg.
`timescale 1ns / 1ps

module sptf_mac
    import sptf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    clear,
    input  mac_issue_t              issue,
    input  logic [SAMPLE_W-1:0]     hist_data,
    output logic signed [ACC_W-1:0] acc_re,
    output logic signed [ACC_W-1:0] acc_im
);

    logic               s1_use_reg;
    logic signed [15:0] s1_cre_reg;
    logic signed [15:0] s1_cim_reg;

    logic               s2_use_reg;
    logic signed [31:0] p_rr_reg;
    logic signed [31:0] p_ii_reg;
    logic signed [31:0] p_ri_reg;
    logic signed [31:0] p_ir_reg;

    logic signed [ACC_W-1:0] acc_re_reg;
    logic signed [ACC_W-1:0] acc_im_reg;
    logic signed [ACC_W-1:0] acc_re_next;
    logic signed [ACC_W-1:0] acc_im_next;

    logic signed [15:0] h_re;
    logic signed [15:0] h_im;
    logic signed [32:0] sum_re;
    logic signed [32:0] sum_im;

    assign h_re = hist_data[15:0];
    assign h_im = hist_data[31:16];

    // re = cr*sr - ci*si, im = cr*si + ci*sr
    assign sum_re = {p_rr_reg[31], p_rr_reg} - {p_ii_reg[31], p_ii_reg};
    assign sum_im = {p_ri_reg[31], p_ri_reg} + {p_ir_reg[31], p_ir_reg};

    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (clear)
        begin
            acc_re_next = '0;
            acc_im_next = '0;
        end
        else if (s2_use_reg)
        begin
            acc_re_next = acc_re_reg + ACC_W'(sum_re);
            acc_im_next = acc_im_reg + ACC_W'(sum_im);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_use_reg <= 1'b0;
            s2_use_reg <= 1'b0;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else
        begin
            s1_use_reg <= issue.use_tap;
            s2_use_reg <= s1_use_reg;
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cre_reg <= issue.coeff_re;
        s1_cim_reg <= issue.coeff_im;
        p_rr_reg   <= 32'(s1_cre_reg) * 32'(h_re);
        p_ii_reg   <= 32'(s1_cim_reg) * 32'(h_im);
        p_ri_reg   <= 32'(s1_cre_reg) * 32'(h_im);
        p_ir_reg   <= 32'(s1_cim_reg) * 32'(h_re);
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

endmodule

FILE: hw/rtl/sparse_tap_complex_fir.sv
// Top level of the sparse-tap complex FIR; instantiates sptf_tap_cell,
// sptf_ram and sptf_mac, and uses sptf_pkg.
`timescale 1ns / 1ps

// Sparse-tap complex FIR for channel emulation. A load word (op = 0) writes
// one tap's delay and Q1.15 coefficient into a ring of MAX_TAPS tap cells;
// it gives no output word. A sample word (op = 1) is written into a
// HISTORY_DEPTH-entry history RAM, after which the tap ring rotates once all
// the way around, presenting one tap per cycle to the single RAM read port and
// a complex MAC; taps at or beyond active_taps, or reaching before the current
// block, add nothing. A sample word therefore occupies the block while it is
// accepted, while the ring rotates, while the read and product stages drain,
// and while the sum is rounded and saturated into the output register.
// The result is held in an output register, so a new word is taken while the
// last result waits; a finished sum waits only if that register is still full.
// The history RAM needs no clearing pass: only entries written since the
// current block began are ever used. active_taps may be written only while
// the block is idle.

module sparse_tap_complex_fir
    import sptf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    // input words
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [4:0]         tap_index,
    input  logic [7:0]         tap_delay,
    input  logic signed [15:0] tap_re,
    input  logic signed [15:0] tap_im,
    input  logic signed [15:0] sample_re,
    input  logic signed [15:0] sample_im,
    input  logic               block_start,
    // output words
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_re,
    output logic signed [15:0] out_im,
    output logic               saturated
);

    // ---------------- control state ----------------
    state_t               state_reg;
    state_t               state_next;
    logic [TAP_IDX_W-1:0] cnt_reg;        // ring rotation count / tap number at head
    logic [TAP_IDX_W-1:0] cnt_next;
    logic                 drain_reg;
    logic                 drain_next;
    logic [HIST_AW-1:0]   wp_reg;         // slot of newest sample
    logic [HIST_AW-1:0]   wp_next;
    logic [SIB_W-1:0]     sib_reg;        // samples in block, saturating
    logic [SIB_W-1:0]     sib_next;
    logic [CFG_W-1:0]     active_taps_reg;

    logic                 out_valid_reg;
    logic [15:0]          out_re_reg;
    logic [15:0]          out_im_reg;
    logic                 saturated_reg;

    // ---------------- FSM outputs ----------------
    logic accept;
    logic accept_sample;
    logic accept_load;
    logic ring_shift;
    logic issue_read;
    logic out_load;

    // ---------------- datapath ----------------
    tap_t                    ring [MAX_TAPS];
    tap_t                    load_tap;
    tap_t                    head;
    mac_issue_t              issue;
    logic [SLOT_W-1:0]       slot_wide;
    logic [HIST_AW-1:0]      slot;
    logic [SAMPLE_W-1:0]     hist_rdata;
    logic signed [ACC_W-1:0] acc_re;
    logic signed [ACC_W-1:0] acc_im;
    rnd_t                    rnd_re;
    rnd_t                    rnd_im;
    logic                    tap_live;

    assign accept        = in_valid && in_ready;
    assign accept_sample = accept && (op == OP_SAMPLE);
    assign accept_load   = accept && (op == OP_LOAD);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_sample)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == TAP_IDX_W'(MAX_TAPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready   = 1'b0;
        ring_shift = 1'b0;
        issue_read = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_RUN:
            begin
                ring_shift = 1'b1;
                issue_read = 1'b1;
            end
            ST_DRAIN:
            begin
                in_ready = 1'b0;
            end
            ST_FINISH:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // counters and sample bookkeeping
    always_comb
    begin
        cnt_next   = cnt_reg;
        drain_next = 1'b0;
        wp_next    = wp_reg;
        sib_next   = sib_reg;
        if (ring_shift)
        begin
            cnt_next = (cnt_reg == TAP_IDX_W'(MAX_TAPS - 1)) ? '0 : cnt_reg + 1'b1;
        end
        if (state_reg == ST_DRAIN)
        begin
            drain_next = !drain_reg;
        end
        if (accept_sample)
        begin
            wp_next = (wp_reg == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (block_start)
            begin
                sib_next = SIB_W'(1);
            end
            else if (sib_reg < SIB_W'(HISTORY_DEPTH))
            begin
                sib_next = sib_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            drain_reg       <= 1'b0;
            wp_reg          <= '0;
            sib_reg         <= '0;
            active_taps_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drain_reg <= drain_next;
            wp_reg    <= wp_next;
            sib_reg   <= sib_next;
            if (cfg_wr_en)
            begin
                active_taps_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_re_reg    <= rnd_re.value;
            out_im_reg    <= rnd_im.value;
            saturated_reg <= rnd_re.clip || rnd_im.clip;
        end
    end

    // ---------------- tap ring ----------------
    // cell i takes cell i+1; after MAX_TAPS shifts the ring is back home,
    // so loads in idle always find tap i in cell i
    assign load_tap.delay    = tap_delay;
    assign load_tap.coeff_re = tap_re;
    assign load_tap.coeff_im = tap_im;

    for (genvar i = 0; i < MAX_TAPS; i++)
    begin : g_cell
        sptf_tap_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .load_en      (accept_load && (int'(tap_index) == i)),
            .load_tap     (load_tap),
            .shift_en     (ring_shift),
            .neighbor_tap (ring[(i + 1) % MAX_TAPS]),
            .tap          (ring[i])
        );
    end

    assign head = ring[0];

    // tap counts if within active_taps and not reaching before the block
    assign tap_live = (CMP_W'(cnt_reg) < CMP_W'(active_taps_reg))
                   && (SLOT_W'(head.delay) < SLOT_W'(sib_reg))
                   && (int'(head.delay) < HISTORY_DEPTH);

    // slot = (wp - delay) mod HISTORY_DEPTH; only used when delay < depth
    always_comb
    begin
        slot_wide = SLOT_W'(wp_reg) + SLOT_W'(HISTORY_DEPTH) - SLOT_W'(head.delay);
        if (slot_wide >= SLOT_W'(HISTORY_DEPTH))
        begin
            slot_wide = slot_wide - SLOT_W'(HISTORY_DEPTH);
        end
        slot = slot_wide[HIST_AW-1:0];
    end

    assign issue.use_tap  = issue_read && tap_live;
    assign issue.coeff_re = head.coeff_re;
    assign issue.coeff_im = head.coeff_im;

    sptf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (accept_sample),
        .waddr (wp_next),
        .wdata ({sample_im, sample_re}),
        .re    (issue_read),
        .raddr (slot),
        .rdata (hist_rdata)
    );

    sptf_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (accept_sample),
        .issue     (issue),
        .hist_data (hist_rdata),
        .acc_re    (acc_re),
        .acc_im    (acc_im)
    );

    assign rnd_re = round_sat(acc_re);
    assign rnd_im = round_sat(acc_im);

    assign out_valid = out_valid_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign saturated = saturated_reg;

    // ---------------- assertions ----------------
    a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cnt_reg == '0))
        else $error("tap ring not at home position while idle");

    a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        accept_sample |-> !issue_read)
        else $error("history write collides with a tap read");

    a_sib_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sib_reg <= SIB_W'(HISTORY_DEPTH))
        else $error("sample count above history depth");

    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        accept_sample |=> (!in_ready && (state_reg == ST_RUN)))
        else $error("sample word did not start a ring pass");

endmodule

FILE: dv/tb_sparse_tap_complex_fir.sv
// Self-checking testbench for sparse_tap_complex_fir: directed and random words
// checked against an in-bench model of the sparse complex delay-line filter.
// Depends on hw/rtl/sptf_pkg.sv and the sparse_tap_complex_fir RTL.
`timescale 1ns / 1ps

module tb_sparse_tap_complex_fir;
    import sptf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;        // cycles with no word moving
    localparam int SETTLE_CYCLES  = MAX_TAPS + 8; // one full sample pass plus margin

    typedef struct packed {
        logic               op;
        logic [4:0]         idx;
        logic [7:0]         dly;
        logic signed [15:0] t_re;
        logic signed [15:0] t_im;
        logic signed [15:0] s_re;
        logic signed [15:0] s_im;
        logic               bstart;
    } fir_word_t;

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               sat;
    } fir_result_t;

    // every input starts at a known value
    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic               op          = OP_SAMPLE;
    logic [4:0]         tap_index   = '0;
    logic [7:0]         tap_delay   = '0;
    logic signed [15:0] tap_re      = '0;
    logic signed [15:0] tap_im      = '0;
    logic signed [15:0] sample_re   = '0;
    logic signed [15:0] sample_im   = '0;
    logic               block_start = 1'b0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;
    logic               saturated;

    // filter model state
    logic signed [15:0] hist_re [HISTORY_DEPTH];
    logic signed [15:0] hist_im [HISTORY_DEPTH];
    logic signed [15:0] coef_re [MAX_TAPS];
    logic signed [15:0] coef_im [MAX_TAPS];
    logic [7:0]         tap_dly [MAX_TAPS];
    int                 blk_count = 0;
    int                 wr_ptr    = 0;
    int                 taps_cfg  = 0;

    fir_result_t pending_out [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int err_count     = 0;
    int quiet_cycles  = 0;

    always #6 clk = ~clk;

    sparse_tap_complex_fir dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .tap_index   (tap_index),
        .tap_delay   (tap_delay),
        .tap_re      (tap_re),
        .tap_im      (tap_im),
        .sample_re   (sample_re),
        .sample_im   (sample_im),
        .block_start (block_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_re      (out_re),
        .out_im      (out_im),
        .saturated   (saturated)
    );

    // ------------------------------------------------------------------
    // Filter model
    // ------------------------------------------------------------------

    // add half an LSB, floor by 2^15, clip to 16 bits
    function automatic logic signed [15:0] round_clip(input longint acc, output logic clipped);
        longint q;
        q = (acc + 64'sd16384) >>> 15;
        clipped = 1'b0;
        if (q > 32767) begin
            q = 32767;
            clipped = 1'b1;
        end
        else if (q < -32768) begin
            q = -32768;
            clipped = 1'b1;
        end
        return q[15:0];
    endfunction

    // apply one accepted word; a sample word queues its filtered output
    task automatic predict_filter_out(input fir_word_t w);
        longint      acc_re;
        longint      acc_im;
        longint      sr, si, cr, ci;
        int          n, l, slot;
        logic        clip_re, clip_im;
        fir_result_t r;
        if (w.op == OP_LOAD) begin
            // 5-bit index always lands inside the 32-entry tap store
            tap_dly[w.idx] = w.dly;
            coef_re[w.idx] = w.t_re;
            coef_im[w.idx] = w.t_im;
        end
        else begin
            if (w.bstart)
                blk_count = 0;
            wr_ptr = (wr_ptr + 1) % HISTORY_DEPTH;
            hist_re[wr_ptr] = w.s_re;
            hist_im[wr_ptr] = w.s_im;
            if (blk_count < HISTORY_DEPTH)
                blk_count++;
            n = (taps_cfg > MAX_TAPS) ? MAX_TAPS : taps_cfg;
            acc_re = 0;
            acc_im = 0;
            for (l = 0; l < n; l++) begin
                // taps reaching before the block start add nothing
                if (int'(tap_dly[l]) < blk_count && int'(tap_dly[l]) < HISTORY_DEPTH) begin
                    slot = (wr_ptr + HISTORY_DEPTH - int'(tap_dly[l])) % HISTORY_DEPTH;
                    sr = hist_re[slot];
                    si = hist_im[slot];
                    cr = coef_re[l];
                    ci = coef_im[l];
                    acc_re += cr * sr - ci * si;
                    acc_im += cr * si + ci * sr;
                end
            end
            r.re  = round_clip(acc_re, clip_re);
            r.im  = round_clip(acc_im, clip_im);
            r.sat = clip_re | clip_im;
            pending_out.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Word builders; fields the block ignores get random values
    // ------------------------------------------------------------------

    function automatic fir_word_t tap_word(input int idx, input int dly,
                                           input logic signed [15:0] re,
                                           input logic signed [15:0] im);
        fir_word_t w;
        w.op     = OP_LOAD;
        w.idx    = idx[4:0];
        w.dly    = dly[7:0];
        w.t_re   = re;
        w.t_im   = im;
        w.s_re   = 16'($urandom);
        w.s_im   = 16'($urandom);
        w.bstart = 1'($urandom);
        return w;
    endfunction

    function automatic fir_word_t sample_word(input logic signed [15:0] re,
                                              input logic signed [15:0] im,
                                              input logic bs);
        fir_word_t w;
        w.op     = OP_SAMPLE;
        w.idx    = 5'($urandom);
        w.dly    = 8'($urandom);
        w.t_re   = 16'($urandom);
        w.t_im   = 16'($urandom);
        w.s_re   = re;
        w.s_im   = im;
        w.bstart = bs;
        return w;
    endfunction

    // mostly samples in long blocks, short delays so taps land inside the block
    function automatic fir_word_t random_word();
        fir_word_t w;
        int        pick;
        w = sample_word(16'($urandom), 16'($urandom), ($urandom_range(99) < 3));
        if ($urandom_range(99) < 10) begin
            w.s_re = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            w.s_im = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        end
        if ($urandom_range(99) < 25) begin
            pick = $urandom_range(99);
            w.op  = OP_LOAD;
            w.dly = 8'((pick < 60) ? $urandom_range(15) :
                       (pick < 80) ? $urandom_range(63) : $urandom_range(255));
            if ($urandom_range(1)) begin
                w.t_re = $signed(16'($urandom_range(4095))) - 16'sd2048;
                w.t_im = $signed(16'($urandom_range(4095))) - 16'sd2048;
            end
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // offer one word at the falling edge, hold it until taken
    task automatic send_word(input fir_word_t w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= w.op;
        tap_index   <= w.idx;
        tap_delay   <= w.dly;
        tap_re      <= w.t_re;
        tap_im      <= w.t_im;
        sample_re   <= w.s_re;
        sample_im   <= w.s_im;
        block_start <= w.bstart;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_filter_out(w);
    endtask

    // drop valid right after the last accepted word, drain, let the ring settle
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_taps(input int n);
        wait_quiet();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n[CFG_W-1:0];
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        taps_cfg = n;
    endtask

    // receiver: long hold-off when requested, otherwise random stalls
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    always @(posedge clk) begin : check_out
        fir_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_out.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected output word re=%0d im=%0d sat=%0b",
                             out_re, out_im, saturated);
            end
            else begin
                want = pending_out.pop_front();
                if (out_re !== want.re || out_im !== want.im || saturated !== want.sat) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: exp re=%0d im=%0d sat=%0b, got re=%0d im=%0d sat=%0b",
                                 want.re, want.im, want.sat, out_re, out_im, saturated);
                end
            end
        end
    end

    // watchdog: cycles in which no word moves on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // zero taps out of reset, then all taps with cleared coefficients
    task automatic test_reset_defaults();
        send_word(sample_word(16'sh7fff, 16'sh8000, 1'b1));
        send_word(sample_word(16'sh1234, 16'sh8765, 1'b0));
        set_taps(32);
        send_word(sample_word(16'sh7fff, 16'sh7fff, 1'b0));
    endtask

    task automatic test_coeff_extremes();
        send_word(tap_word(0, 0, 16'sh7fff, 16'sh8000));
        send_word(tap_word(31, 2, 16'sh8000, 16'sh7fff));
        send_word(tap_word(5, 1, 16'sh0001, 16'shffff));
        set_taps(32);
        send_word(sample_word(16'sh8000, 16'sh7fff, 1'b1));
        send_word(sample_word(16'sh7fff, 16'sh8000, 1'b0));
        send_word(sample_word(16'sh0000, 16'shffff, 1'b0));
        send_word(sample_word(16'sh0001, 16'sh0000, 1'b0));
        send_word(sample_word(16'sh8000, 16'sh8000, 1'b0));
    endtask

    // half-LSB rounding edges, then clipping both ways
    task automatic test_rounding_and_clipping();
        send_word(tap_word(0, 0, 16'sh0001, 16'sh0000));
        set_taps(1);
        send_word(sample_word(-16'sd16384, -16'sd16385, 1'b1));
        send_word(sample_word(16'sd16383, 16'sd16384, 1'b0));
        send_word(sample_word(-16'sd16385, 16'sd16383, 1'b0));
        send_word(tap_word(0, 0, 16'sh8000, 16'sh0000));
        send_word(tap_word(1, 1, 16'sh8000, 16'sh8000));
        set_taps(2);
        send_word(sample_word(16'sh8000, 16'sh8000, 1'b1));
        send_word(sample_word(16'sh7fff, 16'sh7fff, 1'b0));
        send_word(sample_word(16'sh7fff, 16'sh7fff, 1'b0));
    endtask

    // tap counts past the store act as a full ring; zero gives empty sums
    task automatic test_tap_count_limits();
        send_word(tap_word(1, 0, 16'sh0100, 16'sh0200));
        send_word(tap_word(2, 0, 16'sh0300, 16'shfc00));
        send_word(tap_word(31, 0, 16'sh1000, 16'sh0800));
        set_taps(63);
        send_word(sample_word(16'sh2000, 16'she000, 1'b1));
        send_word(sample_word(16'sh0400, 16'sh0400, 1'b0));
        set_taps(33);
        send_word(sample_word(16'sh7fff, 16'sh0000, 1'b0));
        set_taps(0);
        send_word(sample_word(16'sh7fff, 16'sh7fff, 1'b0));
    endtask

    // history from before a block start must not leak into the sum
    task automatic test_block_restart();
        send_word(tap_word(0, 0, 16'sh4000, 16'sh0000));
        send_word(tap_word(1, 1, 16'sh0000, 16'sh4000));
        send_word(tap_word(2, 3, 16'sh2000, 16'sh2000));
        set_taps(3);
        send_word(sample_word(16'sh1000, 16'sh2000, 1'b1));
        repeat (4) send_word(sample_word(16'($urandom), 16'($urandom), 1'b0));
        send_word(sample_word(16'sh3000, 16'shc000, 1'b1));
        send_word(sample_word(16'sh0800, 16'sh0800, 1'b1));
        repeat (3) send_word(sample_word(16'($urandom), 16'($urandom), 1'b0));
    endtask

    // deepest delay only counts once the block holds a full history; wraps the ring
    task automatic test_deep_delay();
        send_word(tap_word(0, 255, 16'sh4000, 16'sh0000));
        send_word(tap_word(1, 0, 16'sh0000, 16'sh2000));
        set_taps(2);
        send_word(sample_word(16'($urandom), 16'($urandom), 1'b1));
        repeat (299) send_word(sample_word(16'($urandom), 16'($urandom), 1'b0));
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_backpressure();
        int saved_pct;
        saved_pct = send_idle_pct;
        send_idle_pct = 0;
        set_taps(32);
        hold_left = 600;
        repeat (24) send_word(sample_word(16'($urandom), 16'($urandom), 1'b0));
        send_idle_pct = saved_pct;
    endtask

    task automatic test_random_traffic(input int n_words, input int s_pct, input int r_pct);
        int chunk;
        int pick;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (chunk = 0; chunk < 4; chunk++) begin
            pick = $urandom_range(3);
            set_taps((pick < 2) ? $urandom_range(1, 32) :
                     (pick == 2) ? 32 : $urandom_range(0, 63));
            repeat (n_words / 4) send_word(random_word());
        end
    endtask

    initial begin
        int i;
        for (i = 0; i < HISTORY_DEPTH; i++) begin
            hist_re[i] = '0;
            hist_im[i] = '0;
        end
        for (i = 0; i < MAX_TAPS; i++) begin
            coef_re[i] = '0;
            coef_im[i] = '0;
            tap_dly[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 13;
        recv_idle_pct = 82;
        test_reset_defaults();
        test_coeff_extremes();
        test_rounding_and_clipping();
        test_tap_count_limits();
        test_block_restart();
        test_deep_delay();
        test_output_backpressure();

        test_random_traffic(496, 13, 82);
        test_random_traffic(496, 82, 13);
        test_random_traffic(496, 0, 0);

        wait_quiet();
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
